// ===== src/htbm_pkg.sv =====
package htbm_pkg;

  localparam int unsigned CFG_W     = 40;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned TIME_W    = 48;
  localparam int unsigned TOK_W     = 43;
  localparam int unsigned SUM_W     = 45;
  localparam int unsigned DIFF_W    = 51;
  localparam int unsigned BYTES_W   = 17;
  localparam int unsigned NUM_W     = 49;
  localparam int unsigned WAIT_W    = 41;
  localparam int unsigned PROD_W    = 50;

  localparam int unsigned FRAME_OVERHEAD_DEF = 7;

  localparam logic [29:0] NS_PER_S = 30'd1_000_000_000;
  localparam logic [TOK_W-1:0] TOK_MAX = {1'b0, {(TOK_W-1){1'b1}}};

  // Command codes of an item.
  localparam logic [1:0] FUNC_QUERY   = 2'd0;
  localparam logic [1:0] FUNC_CHARGE  = 2'd1;
  localparam logic [1:0] FUNC_REFRESH = 2'd2;

  // Class colours.
  localparam logic [1:0] COL_CANNOT = 2'd0;
  localparam logic [1:0] COL_BORROW = 2'd1;
  localparam logic [1:0] COL_CAN    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CEIL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CBURST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFLIM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST   = 3'd5;

  localparam logic [CFG_W-1:0] RATE_RST   = 40'd1_000_000;
  localparam logic [CFG_W-1:0] BURST_RST  = 40'd1_000_000;
  localparam logic [CFG_W-1:0] BUFLIM_RST = 40'd1_000_000_000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV_RATE,
    ST_WAIT_RATE,
    ST_DIV_CEIL,
    ST_WAIT_CEIL,
    ST_APPLY,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic cap;
    logic div_start;
    logic div_ceil;
    logic take_q;
    logic apply;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic charge;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

// ===== src/htbm_item_if.sv =====
interface htbm_item_if;
  import htbm_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          func;
  logic [TIME_W-1:0]   now_ns;
  logic [15:0]         packet_bytes;
  logic                charge_rate;

  modport source (output valid, func, now_ns, packet_bytes, charge_rate, input ready);
  modport sink   (input valid, func, now_ns, packet_bytes, charge_rate, output ready);
endinterface

// ===== src/htbm_result_if.sv =====
interface htbm_result_if;
  import htbm_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        colour;
  logic [WAIT_W-1:0] wait_ns;
  logic              mode_changed;

  modport source (output valid, colour, wait_ns, mode_changed, input ready);
  modport sink   (input valid, colour, wait_ns, mode_changed, output ready);
endinterface

// ===== src/htb_class_token_meter.sv =====
// Meters one hierarchical token bucket class with a rate bucket and a ceiling
// bucket, both in nanoseconds. One item is taken at a time. A query or refresh
// beat is loaded, then passes through the prep and finish states. A charge
// beat also runs the shared restoring divider between those states, which
// works out the packet cost once for the assured rate and once for the
// ceiling rate, one quotient bit per cycle, and then the apply state updates
// the buckets. The next beat is taken the cycle after the result is loaded
// into the output register, so a result may wait there while the next item
// runs; that item then holds in its last cycle until the output register is
// free. Configuration must be written through cfg_we/cfg_index/cfg_data only
// while the block is idle; the block itself does not enforce this. A rate
// of zero acts as one.
module htb_class_token_meter
  import htbm_pkg::*;
#(
  parameter int unsigned FRAME_OVERHEAD = FRAME_OVERHEAD_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  htbm_item_if.sink            item,
  htbm_result_if.source        result
);

  cmd_t    cmd;
  status_t status;

  htbm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  htbm_dp #(
    .FRAME_OVERHEAD (FRAME_OVERHEAD)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .func_in        (item.func),
    .now_in         (item.now_ns),
    .bytes_in       (item.packet_bytes),
    .charge_rate_in (item.charge_rate),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .res_colour     (result.colour),
    .res_wait       (result.wait_ns),
    .res_changed    (result.mode_changed),
    .cmd            (cmd),
    .status         (status)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("item accepted while another is in progress");

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> result.valid)
    else $error("finished result not presented");

  a_div_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> status.div_busy)
    else $error("divider did not start");

  a_apply_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |-> !status.div_busy)
    else $error("tokens updated while divider busy");
`endif

endmodule

// ===== src/htbm_div.sv =====
module htbm_div
  import htbm_pkg::*;
#(
  parameter int unsigned NUM_BITS = NUM_W,
  parameter int unsigned DEN_BITS = CFG_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] numer,
  input  logic [DEN_BITS-1:0] denom,
  output logic                busy,
  output logic [NUM_BITS-1:0] quo
);

  localparam int unsigned CNT_W = $clog2(NUM_BITS + 1);

  logic [CNT_W-1:0]    count;
  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS-1:0] denom_q;
  logic [DEN_BITS:0]   shifted;
  logic [DEN_BITS:0]   diff;
  logic                fits;

  // Restoring division: one quotient bit a cycle, numerator bits shift out
  // of the top of quo while quotient bits shift in at the bottom.
  assign shifted = {rem, quo[NUM_BITS-1]};
  assign diff    = shifted - {1'b0, denom_q};
  assign fits    = shifted >= {1'b0, denom_q};
  assign busy    = count != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CNT_W'(NUM_BITS);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      quo     <= numer;
      denom_q <= denom;
    end else if (busy) begin
      rem <= fits ? diff[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
      quo <= {quo[NUM_BITS-2:0], fits};
    end
  end

endmodule

// ===== src/htbm_ctrl.sv =====
module htbm_ctrl
  import htbm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = status.charge ? ST_DIV_RATE : ST_FINISH;
      end
      ST_DIV_RATE: begin
        cmd.cap       = 1'b1;
        cmd.div_start = 1'b1;
        state_next    = ST_WAIT_RATE;
      end
      ST_WAIT_RATE: begin
        if (!status.div_busy) begin
          cmd.take_q = 1'b1;
          state_next = ST_DIV_CEIL;
        end
      end
      ST_DIV_CEIL: begin
        cmd.div_start = 1'b1;
        cmd.div_ceil  = 1'b1;
        state_next    = ST_WAIT_CEIL;
      end
      ST_WAIT_CEIL: begin
        cmd.div_ceil = 1'b1;
        if (!status.div_busy) begin
          cmd.take_q = 1'b1;
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== src/htbm_dp.sv =====
module htbm_dp
  import htbm_pkg::*;
#(
  parameter int unsigned FRAME_OVERHEAD = FRAME_OVERHEAD_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [1:0]           func_in,
  input  logic [TIME_W-1:0]    now_in,
  input  logic [15:0]          bytes_in,
  input  logic                 charge_rate_in,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [1:0]           res_colour,
  output logic [WAIT_W-1:0]    res_wait,
  output logic                 res_changed,
  input  cmd_t                 cmd,
  output status_t              status
);

  // Configuration registers.
  logic [CFG_W-1:0] rate_bps, ceil_bps, burst_ns, cburst_ns, buffer_limit_ns;
  logic             hysteresis_on;

  // Class state.
  logic signed [TOK_W-1:0] rate_tokens, ceil_tokens;
  logic [1:0]              class_mode;
  logic [TIME_W-1:0]       checkpoint_ns;

  // Item held for the duration of its work.
  logic [1:0]         func;
  logic [TIME_W-1:0]  now_ns;
  logic [BYTES_W-1:0] bytes;
  logic               charge_rate;

  logic [CFG_W-1:0]         elapsed;
  logic [NUM_W-1:0]         numer;
  logic [NUM_W-1:0]         q_rate, q_ceil;
  logic signed [SUM_W-1:0]  rate_capped, ceil_capped;
  logic signed [TOK_W-1:0]  rate_grown;

  logic [TIME_W-1:0]        gap;
  logic [PROD_W-1:0]        prod;
  logic signed [SUM_W-1:0]  rate_sum, ceil_sum;
  logic signed [SUM_W-1:0]  low_water, high_water;
  logic signed [TOK_W-1:0]  rate_floored, ceil_floored;
  logic [CFG_W-1:0]         div_denom;
  logic [NUM_W-1:0]         div_quo;
  logic                     div_busy;
  logic [1:0]               colour;
  logic [WAIT_W-1:0]        wait_val;
  logic                     updates_mode;

  function automatic logic signed [TOK_W-1:0] floor_at_limit(
    input logic signed [SUM_W-1:0] level,
    input logic [NUM_W-1:0]        cost,
    input logic [CFG_W-1:0]        limit
  );
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] neg_limit;
    diff      = $signed({{(DIFF_W-SUM_W){level[SUM_W-1]}}, level})
              - $signed({{(DIFF_W-NUM_W){1'b0}}, cost});
    neg_limit = -$signed({{(DIFF_W-CFG_W){1'b0}}, limit});
    if (diff <= neg_limit) begin
      floor_at_limit = $signed(TOK_W'(1) - {{(TOK_W-CFG_W){1'b0}}, limit});
    end else begin
      floor_at_limit = diff[TOK_W-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_bps        <= RATE_RST;
      ceil_bps        <= RATE_RST;
      burst_ns        <= BURST_RST;
      cburst_ns       <= BURST_RST;
      buffer_limit_ns <= BUFLIM_RST;
      hysteresis_on   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RATE:   rate_bps        <= cfg_data;
        CFG_CEIL:   ceil_bps        <= cfg_data;
        CFG_BURST:  burst_ns        <= cfg_data;
        CFG_CBURST: cburst_ns       <= cfg_data;
        CFG_BUFLIM: buffer_limit_ns <= cfg_data;
        CFG_HYST:   hysteresis_on   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign gap  = (now_ns >= checkpoint_ns) ? now_ns - checkpoint_ns : '0;
  assign prod = {bytes, 3'b000} * NS_PER_S;

  assign rate_sum = $signed({{(SUM_W-TOK_W){rate_tokens[TOK_W-1]}}, rate_tokens})
                  + $signed({{(SUM_W-CFG_W){1'b0}}, elapsed});
  assign ceil_sum = $signed({{(SUM_W-TOK_W){ceil_tokens[TOK_W-1]}}, ceil_tokens})
                  + $signed({{(SUM_W-CFG_W){1'b0}}, elapsed});

  assign div_denom = cmd.div_ceil ? ((ceil_bps == '0) ? CFG_W'(1) : ceil_bps)
                                  : ((rate_bps == '0) ? CFG_W'(1) : rate_bps);

  htbm_div #(
    .NUM_BITS (NUM_W),
    .DEN_BITS (CFG_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .numer (numer),
    .denom (div_denom),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  assign rate_floored = floor_at_limit(rate_capped, q_rate, buffer_limit_ns);
  assign ceil_floored = floor_at_limit(ceil_capped, q_ceil, buffer_limit_ns);

  // With hysteresis, a class that may send keeps doing so until it is a full
  // burst in debt, and one that has stopped stays stopped until its ceiling
  // bucket is back at zero.
  assign low_water  = (hysteresis_on && class_mode != COL_CANNOT)
                    ? -$signed({{(SUM_W-CFG_W){1'b0}}, cburst_ns}) : '0;
  assign high_water = (hysteresis_on && class_mode == COL_CAN)
                    ? -$signed({{(SUM_W-CFG_W){1'b0}}, burst_ns}) : '0;

  always_comb begin
    if (ceil_sum < low_water) begin
      colour   = COL_CANNOT;
      wait_val = WAIT_W'(-ceil_sum);
    end else if (rate_sum >= high_water) begin
      colour   = COL_CAN;
      wait_val = '0;
    end else begin
      colour   = COL_BORROW;
      wait_val = WAIT_W'(-rate_sum);
    end
  end

  assign updates_mode = (func == FUNC_CHARGE) || (func == FUNC_REFRESH);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func        <= func_in;
      now_ns      <= now_in;
      bytes       <= {1'b0, bytes_in} + BYTES_W'(FRAME_OVERHEAD);
      charge_rate <= charge_rate_in;
    end
    if (cmd.prep) begin
      elapsed <= (gap < {{(TIME_W-CFG_W){1'b0}}, buffer_limit_ns})
               ? gap[CFG_W-1:0] : buffer_limit_ns;
      numer   <= prod[NUM_W-1:0];
    end
    if (cmd.cap) begin
      rate_capped <= (rate_sum > $signed({{(SUM_W-CFG_W){1'b0}}, burst_ns}))
                   ? $signed({{(SUM_W-CFG_W){1'b0}}, burst_ns}) : rate_sum;
      ceil_capped <= (ceil_sum > $signed({{(SUM_W-CFG_W){1'b0}}, cburst_ns}))
                   ? $signed({{(SUM_W-CFG_W){1'b0}}, cburst_ns}) : ceil_sum;
      rate_grown  <= (rate_sum > $signed({{(SUM_W-TOK_W){1'b0}}, TOK_MAX}))
                   ? $signed(TOK_MAX) : rate_sum[TOK_W-1:0];
    end
    if (cmd.take_q) begin
      if (cmd.div_ceil) begin
        q_ceil <= div_quo;
      end else begin
        q_rate <= div_quo;
      end
    end
    // After a charge the colour is taken at the new checkpoint.
    if (cmd.apply) begin
      elapsed <= '0;
    end
    if (cmd.finish) begin
      res_colour  <= colour;
      res_wait    <= wait_val;
      res_changed <= updates_mode && (colour != class_mode);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_tokens   <= $signed({{(TOK_W-CFG_W){1'b0}}, BURST_RST});
      ceil_tokens   <= $signed({{(TOK_W-CFG_W){1'b0}}, BURST_RST});
      class_mode    <= COL_CAN;
      checkpoint_ns <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (cmd.apply) begin
        rate_tokens   <= charge_rate ? rate_floored : rate_grown;
        ceil_tokens   <= ceil_floored;
        checkpoint_ns <= now_ns;
      end
      if (cmd.finish && updates_mode) begin
        class_mode <= colour;
      end
      if (cmd.finish) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign status.charge   = func == FUNC_CHARGE;
  assign status.div_busy = div_busy;
  assign status.out_free = !res_valid || res_ready;

endmodule

// ===== tb/sv/tb_htb_class_token_meter.sv =====
module tb_htb_class_token_meter;
  timeunit 1ns;
  timeprecision 1ps;

  import htbm_pkg::*;

  // A command code the block does not define; it must behave as a query.
  localparam logic [1:0] FUNC_UNDEF = 2'd3;

  localparam longint unsigned BIT_NS_PER_S = 64'd8_000_000_000;
  localparam longint unsigned MAX40        = 64'h0000_00FF_FFFF_FFFF;
  localparam longint unsigned MAX_NS       = 64'h0000_FFFF_FFFF_FFFF;
  localparam longint unsigned SPAN_CAP     = 64'd1 << 36;
  localparam int              CYCLE_LIMIT  = 1_000_000;
  localparam int              HOLD_AT      = 300;
  localparam int              HOLD_CYCLES  = 700;

  typedef struct packed {
    logic [1:0]        func;
    logic [TIME_W-1:0] now;
    logic [15:0]       bytes;
    logic              charge_rate;
  } meter_beat_t;

  typedef struct packed {
    logic [1:0]        colour;
    logic [WAIT_W-1:0] wait_ns;
    logic              mode_changed;
  } verdict_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  htbm_item_if   item_ch ();
  htbm_result_if result_ch ();

  htb_class_token_meter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  // Shadow copy of the registers and of the class state.
  longint unsigned rate_cfg, ceil_cfg, burst_cfg, cburst_cfg, buflim_cfg;
  bit              hyst_cfg;
  longint          rate_lvl, ceil_lvl;
  logic [1:0]      mode_now;
  logic [TIME_W-1:0] chk_ns;

  meter_beat_t beats_to_send[$];
  verdict_t    verdicts_due[$];
  meter_beat_t offered;
  verdict_t    fresh, oldest_due;

  longint unsigned cur_ns;
  int beats_queued, beats_in, results_in, mismatches, cycle_count, settings_run;
  int charges_seen, queries_seen, refreshes_seen, mode_flips;
  int colour_hits[3];
  int burst_left, gap_left;
  int hold_left, seg_left, stall_pct;
  bit hold_done;

  function automatic logic [1:0] grade(input longint elapsed,
                                       output logic [WAIT_W-1:0] wait_ns);
    longint lvl, low_mark, high_mark;
    logic [63:0] neg;
    low_mark = 0;
    high_mark = 0;
    if (hyst_cfg && mode_now != COL_CANNOT) low_mark = -longint'(cburst_cfg);
    if (hyst_cfg && mode_now == COL_CAN) high_mark = -longint'(burst_cfg);
    lvl = ceil_lvl + elapsed;
    if (lvl < low_mark) begin
      neg = -lvl;
      wait_ns = neg[WAIT_W-1:0];
      return COL_CANNOT;
    end
    lvl = rate_lvl + elapsed;
    if (lvl >= high_mark) begin
      wait_ns = '0;
      return COL_CAN;
    end
    neg = -lvl;
    wait_ns = neg[WAIT_W-1:0];
    return COL_BORROW;
  endfunction

  // Refill by the elapsed time, clip at the bucket depth, take the packet cost
  // and keep the level above the buffer floor.
  function automatic longint debit(input longint lvl, input longint elapsed,
                                   input longint unsigned depth,
                                   input longint unsigned bps,
                                   input longint unsigned bytes);
    longint t;
    longint unsigned divisor;
    divisor = (bps == 0) ? 64'd1 : bps;
    t = lvl + elapsed;
    if (t > longint'(depth)) t = longint'(depth);
    t = t - longint'((bytes * BIT_NS_PER_S) / divisor);
    if (t <= -longint'(buflim_cfg)) t = 1 - longint'(buflim_cfg);
    return t;
  endfunction

  function automatic void meter_beat(input meter_beat_t b, output verdict_t v);
    longint unsigned gap, bytes;
    longint elapsed, t;
    logic [1:0] col;
    logic [WAIT_W-1:0] w;
    gap = (b.now >= chk_ns) ? 64'(b.now) - 64'(chk_ns) : 64'd0;
    elapsed = longint'((gap < buflim_cfg) ? gap : buflim_cfg);
    bytes = 64'(b.bytes) + FRAME_OVERHEAD_DEF;
    if (b.func == FUNC_CHARGE) begin
      if (b.charge_rate) begin
        rate_lvl = debit(rate_lvl, elapsed, burst_cfg, rate_cfg, bytes);
      end else begin
        t = rate_lvl + elapsed;
        rate_lvl = (t > longint'(TOK_MAX)) ? longint'(TOK_MAX) : t;
      end
      ceil_lvl = debit(ceil_lvl, elapsed, cburst_cfg, ceil_cfg, bytes);
      chk_ns = b.now;
      col = grade(0, w);
      charges_seen++;
    end else begin
      col = grade(elapsed, w);
      if (b.func == FUNC_REFRESH) refreshes_seen++;
      else queries_seen++;
    end
    v.mode_changed = 1'b0;
    if (b.func == FUNC_CHARGE || b.func == FUNC_REFRESH) begin
      v.mode_changed = (col != mode_now);
      mode_now = col;
    end
    if (v.mode_changed) mode_flips++;
    colour_hits[col]++;
    v.colour = col;
    v.wait_ns = w;
  endfunction

  function automatic longint unsigned rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_beat(input logic [1:0] code, input longint unsigned now,
                           input logic [15:0] bytes, input logic cr);
    meter_beat_t b;
    b.func = code;
    b.now = now[TIME_W-1:0];
    b.bytes = bytes;
    b.charge_rate = cr;
    beats_to_send = {beats_to_send, b};
    beats_queued++;
  endtask

  // Mostly a well-formed stream with time moving forward on the scale of one
  // packet cost; the rest is stray time stamps and charges behind the checkpoint.
  task automatic queue_traffic(input int n);
    longint unsigned cost_scale, span, advance, back;
    logic [15:0] bytes;
    logic cr;
    int pick;
    cost_scale = (1507 * BIT_NS_PER_S) / ((rate_cfg == 0) ? 64'd1 : rate_cfg);
    if (cost_scale > SPAN_CAP) cost_scale = SPAN_CAP;
    if (cost_scale == 0) cost_scale = 1;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) begin
        span = (buflim_cfg < SPAN_CAP) ? buflim_cfg * 2 : SPAN_CAP * 2;
      end else begin
        span = cost_scale * 2;
      end
      advance = rand64() % (span + 1);
      if (cur_ns + advance > MAX_NS) advance = 0;
      bytes = ($urandom_range(0, 6) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
      cr = ($urandom_range(0, 4) != 0);
      if (pick < 55) begin
        cur_ns += advance;
        push_beat(FUNC_CHARGE, cur_ns, bytes, cr);
      end else if (pick < 72) begin
        cur_ns += advance;
        push_beat(FUNC_QUERY, cur_ns, bytes, cr);
      end else if (pick < 86) begin
        cur_ns += advance;
        push_beat(FUNC_REFRESH, cur_ns, bytes, cr);
      end else if (pick < 90) begin
        push_beat(FUNC_UNDEF, cur_ns, bytes, cr);
      end else if (pick < 95) begin
        push_beat($urandom_range(0, 1) ? FUNC_QUERY : FUNC_REFRESH,
                  {16'($urandom), 32'($urandom)}, bytes, cr);
      end else begin
        back = rand64() % (cost_scale + 1);
        push_beat(FUNC_CHARGE, (cur_ns > back) ? cur_ns - back : 64'd0, bytes, cr);
      end
    end
  endtask

  task automatic drain();
    while (beats_in != beats_queued || verdicts_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input longint unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_W-1:0];
    case (idx)
      CFG_RATE:   rate_cfg = value & MAX40;
      CFG_CEIL:   ceil_cfg = value & MAX40;
      CFG_BURST:  burst_cfg = value & MAX40;
      CFG_CBURST: cburst_cfg = value & MAX40;
      CFG_BUFLIM: buflim_cfg = value & MAX40;
      CFG_HYST:   hyst_cfg = value[0];
      default: ;
    endcase
  endtask

  task automatic reconfigure(input longint unsigned rate, input longint unsigned ceil,
                             input longint unsigned burst, input longint unsigned cburst,
                             input longint unsigned buflim, input bit hyst);
    drain();
    repeat (4) @(posedge clk);
    set_reg(CFG_RATE, rate);
    set_reg(CFG_CEIL, ceil);
    set_reg(CFG_BURST, burst);
    set_reg(CFG_CBURST, cburst);
    set_reg(CFG_BUFLIM, buflim);
    set_reg(CFG_HYST, 64'(hyst));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    settings_run++;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_RATE;
    cfg_data <= '0;

    rate_cfg = RATE_RST;
    ceil_cfg = RATE_RST;
    burst_cfg = BURST_RST;
    cburst_cfg = BURST_RST;
    buflim_cfg = BUFLIM_RST;
    hyst_cfg = 1'b0;
    rate_lvl = longint'(BURST_RST);
    ceil_lvl = longint'(BURST_RST);
    mode_now = COL_CAN;
    chk_ns = '0;
    settings_run = 1;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed run under the reset settings.
    push_beat(FUNC_QUERY, 0, 16'd0, 1'b1);
    push_beat(FUNC_UNDEF, 0, 16'd100, 1'b0);
    push_beat(FUNC_REFRESH, 0, 16'd0, 1'b1);
    push_beat(FUNC_CHARGE, 0, 16'd0, 1'b1);
    push_beat(FUNC_CHARGE, 1000, 16'hFFFF, 1'b1);
    // A second full-size packet drives both buckets through the floor.
    push_beat(FUNC_CHARGE, 2000, 16'hFFFF, 1'b1);
    push_beat(FUNC_QUERY, MAX_NS, 16'd0, 1'b0);
    push_beat(FUNC_REFRESH, MAX_NS, 16'hFFFF, 1'b1);
    push_beat(FUNC_CHARGE, 1500, 16'd200, 1'b0);
    push_beat(FUNC_CHARGE, 64'd1_000_002_000, 16'd0, 1'b0);
    push_beat(FUNC_CHARGE, 64'd1_000_010_000, 16'd1500, 1'b1);
    push_beat(FUNC_QUERY, 64'd1_000_500_000, 16'd0, 1'b0);
    push_beat(FUNC_REFRESH, 64'd1_001_000_000, 16'd0, 1'b0);
    push_beat(FUNC_CHARGE, 64'd1_003_000_000, 16'd1500, 1'b0);
    push_beat(FUNC_CHARGE, 64'd1_003_000_000, 16'd1500, 1'b1);
    push_beat(FUNC_QUERY, 64'h0000_AAAA_AAAA_AAAA, 16'hAAAA, 1'b1);
    push_beat(FUNC_REFRESH, 64'h0000_5555_5555_5555, 16'h5555, 1'b0);
    push_beat(FUNC_UNDEF, 64'd1_004_000_000, 16'd64, 1'b1);
    cur_ns = 64'd1_010_000_000;

    reconfigure(64'd1_000_000, 64'd4_000_000, 64'd2_000_000, 64'd1_000_000,
                64'd50_000_000, 1'b0);
    queue_traffic(130);
    reconfigure(64'd8_000_000, 64'd20_000_000, 64'd500_000, 64'd3_000_000,
                64'd10_000_000, 1'b1);
    queue_traffic(150);
    reconfigure(MAX40, MAX40, 64'd0, 64'd0, 64'd1, 1'b1);
    queue_traffic(60);

    // Slowest rates, a ceiling of zero, deepest buckets and the widest buffer;
    // time-only charges over whole buffers push the rate bucket into saturation.
    reconfigure(64'd1, 64'd0, MAX40, MAX40, MAX40, 1'b0);
    for (int i = 0; i < 6; i++) begin
      cur_ns += MAX40 + 1;
      push_beat(FUNC_CHARGE, cur_ns, 16'($urandom), 1'b0);
    end
    push_beat(FUNC_QUERY, cur_ns, 16'd0, 1'b0);
    queue_traffic(60);

    reconfigure($urandom_range(100_000, 2_000_000_000), $urandom_range(100_000, 2_000_000_000),
                $urandom_range(0, 50_000_000), $urandom_range(0, 50_000_000),
                $urandom_range(1000, 100_000_000), 1'($urandom_range(0, 1)));
    queue_traffic(130);
    reconfigure($urandom_range(500_000, 50_000_000), $urandom_range(1_000_000, 100_000_000),
                $urandom_range(0, 20_000_000), $urandom_range(0, 20_000_000),
                $urandom_range(1_000_000, 1_000_000_000), 1'b1);
    queue_traffic(130);
    reconfigure($urandom_range(1_000, 10_000_000), $urandom_range(1_000, 10_000_000),
                $urandom_range(0, 5_000_000), $urandom_range(0, 5_000_000),
                $urandom_range(1, 20_000_000), 1'b0);
    queue_traffic(130);

    drain();
    repeat (20) @(posedge clk);
    $display("Run covered %0d beats under %0d register settings: %0d charges, %0d %s",
             beats_in, settings_run, charges_seen, queries_seen, "queries,");
    $display("  %0d refreshes.", refreshes_seen);
    $display("Colours returned: %0d cannot send, %0d may borrow, %0d can send;",
             colour_hits[COL_CANNOT], colour_hits[COL_BORROW], colour_hits[COL_CAN]);
    $display("  mode changed %0d times.", mode_flips);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Sender: bursts of back-to-back beats separated by gaps of random length.
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      item_ch.func <= FUNC_QUERY;
      item_ch.now_ns <= '0;
      item_ch.packet_bytes <= '0;
      item_ch.charge_rate <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        meter_beat(offered, fresh);
        verdicts_due = {verdicts_due, fresh};
        beats_in++;
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          item_ch.valid <= 1'b0;
        end else if (beats_to_send.size() > 0) begin
          offered = beats_to_send.pop_front();
          item_ch.func <= offered.func;
          item_ch.now_ns <= offered.now;
          item_ch.packet_bytes <= offered.bytes;
          item_ch.charge_rate <= offered.charge_rate;
          item_ch.valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 19))
              0, 1, 2:            gap_left = $urandom_range(1, 130);
              3, 4, 5, 6, 7, 8, 9: gap_left = $urandom_range(1, 8);
              default:            gap_left = 0;
            endcase
          end
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall density changes from one stretch to the next, and once the
  // sink holds off long enough for the block to back up onto its input.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      seg_left = 0;
      stall_pct = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else if (!hold_done && beats_in >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      result_ch.ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 200);
        case ($urandom_range(0, 4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 30;
          3:       stall_pct = 70;
          default: stall_pct = 95;
        endcase
      end else begin
        seg_left--;
      end
      result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (verdicts_due.size() == 0) begin
        $error("result beat with nothing outstanding: colour %0d, wait_ns %0d, mode_changed %0d",
               result_ch.colour, result_ch.wait_ns, result_ch.mode_changed);
        mismatches++;
      end else begin
        oldest_due = verdicts_due.pop_front();
        if (result_ch.colour !== oldest_due.colour) begin
          $error("colour: expected %0d, actual %0d", oldest_due.colour, result_ch.colour);
          mismatches++;
        end
        if (result_ch.wait_ns !== oldest_due.wait_ns) begin
          $error("wait_ns: expected %0d, actual %0d", oldest_due.wait_ns, result_ch.wait_ns);
          mismatches++;
        end
        if (result_ch.mode_changed !== oldest_due.mode_changed) begin
          $error("mode_changed: expected %0d, actual %0d",
                 oldest_due.mode_changed, result_ch.mode_changed);
          mismatches++;
        end
        results_in++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results still due.",
               cycle_count, verdicts_due.size());
      $display("FAILURE");
      $finish;
    end
  end

endmodule

// ===== files.f =====
src/htbm_pkg.sv
src/htbm_item_if.sv
src/htbm_result_if.sv
src/htbm_div.sv
src/htbm_ctrl.sv
src/htbm_dp.sv
src/htb_class_token_meter.sv
tb/sv/tb_htb_class_token_meter.sv
